@@ hw/rtl/rdi_pkg.sv @@
// rdi_pkg: shared constants, angle table and sideband types for the ray/disk block
// no dependencies
`default_nettype none

package rdi_pkg;

	// fixed-point format of lengths, angles and coordinates
	localparam int FRAC = 16;
	// angle format inside the cordic unit
	localparam int ANG_BITS = 30;
	localparam int CORDIC_STEPS = 30;
	localparam logic [30:0] ANG_HALF_PI = 31'd1686629713;
	localparam logic [32:0] ANG_PI = 33'd3373259426;
	localparam logic [32:0] ANG_TWO_PI = 33'd6746518852;
	localparam logic [32:0] ANG_ROUND = 33'd1 << (ANG_BITS - 1 - FRAC);

	// configuration register indexes
	localparam logic [1:0] REG_DISK_HEIGHT = 2'd0;
	localparam logic [1:0] REG_OUTER_RADIUS = 2'd1;
	localparam logic [1:0] REG_INNER_RADIUS = 2'd2;
	localparam logic [1:0] REG_SWEEP_ANGLE = 2'd3;

	// atan(2^-k) in Q30
	function automatic logic [30:0] atan_q30(input int k);
		logic [30:0] a;
		case (k)
			0: a = 31'd843314857;
			1: a = 31'd497837829;
			2: a = 31'd263043837;
			3: a = 31'd133525159;
			4: a = 31'd67021687;
			5: a = 31'd33543516;
			6: a = 31'd16775851;
			7: a = 31'd8388437;
			8: a = 31'd4194283;
			9: a = 31'd2097149;
			default: a = 31'd1 << (30 - k);
		endcase
		return a;
	endfunction

	// payload carried alongside the distance divider
	typedef struct packed {
		logic signed [31:0] ox;
		logic signed [31:0] oy;
		logic signed [31:0] dx;
		logic signed [31:0] dy;
		logic [30:0] tmax;
		logic miss;
	} tdiv_side_t;

	// payload carried alongside the square root
	typedef struct packed {
		logic [30:0] ax;
		logic [30:0] ay;
		logic pxn;
		logic pyn;
		logic [30:0] t;
		logic miss;
	} sqrt_side_t;

	// payload carried alongside the angle unit
	typedef struct packed {
		logic [31:0] r;
		logic pxn;
		logic pyn;
		logic [30:0] t;
		logic miss;
	} cordic_side_t;

	// payload carried alongside the u divider
	typedef struct packed {
		logic [30:0] t;
		logic miss;
	} udiv_side_t;

endpackage

`default_nettype wire

@@ hw/rtl/ray_disk_intersect.sv @@
// ray_disk_intersect: ray against partial annulus test, fully pipelined
// depends on rdi_pkg, rdi_divider, rdi_isqrt, rdi_cordic
//
//  channel   handshake        payload
//  request   start / busy     origin_x/y/z, dir_x/y/z, t_max
//  result    done             hit, t_hit, u_coord, v_coord
//  config    cfg_we           cfg_index, cfg_data
//
// one ray enters every cycle; busy is always low
// each ray passes through the 48-stage distance divider, the 32-stage
// square root, the 36-stage angle unit and the 17-stage u/v dividers in series
// reset clears the valid bits and loads the register defaults
// every request gives exactly one result; the receiver cannot stall
`default_nettype none

module ray_disk_intersect (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic [30:0] t_max,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic        hit,
	output logic [30:0] t_hit,
	output logic [16:0] u_coord,
	output logic [16:0] v_coord
);

	import rdi_pkg::*;

	// configuration registers
	logic signed [31:0] disk_height_q;
	logic [30:0] outer_q;
	logic [30:0] inner_q;
	logic [18:0] sweep_q;
	logic [61:0] rsq_q;
	logic [61:0] risq_q;
	logic [30:0] width_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_height_q <= '0;
			outer_q <= 31'd1 << FRAC;
			inner_q <= '0;
			sweep_q <= 19'd411775;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DISK_HEIGHT:  disk_height_q <= cfg_data;
				REG_OUTER_RADIUS: outer_q <= cfg_data[30:0];
				REG_INNER_RADIUS: inner_q <= cfg_data[30:0];
				REG_SWEEP_ANGLE:  sweep_q <= cfg_data[18:0];
				default: ;
			endcase
		end
	end

	// squared radii follow the registers in the next cycle
	always_ff @(posedge clk) begin
		rsq_q <= 62'(outer_q) * 62'(outer_q);
		risq_q <= 62'(inner_q) * 62'(inner_q);
	end

	assign width_w = outer_q - inner_q;
	assign busy = 1'b0;

	// stage 1: capture the request, plane offset
	logic v_s1;
	logic signed [31:0] ox_s1, oy_s1, dx_s1, dy_s1, dz_s1;
	logic [30:0] tmax_s1;
	logic signed [32:0] num_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ox_s1 <= origin_x;
		oy_s1 <= origin_y;
		dx_s1 <= dir_x;
		dy_s1 <= dir_y;
		dz_s1 <= dir_z;
		tmax_s1 <= t_max;
		num_s1 <= {disk_height_q[31], disk_height_q} - {origin_z[31], origin_z};
	end

	// stage 2: magnitudes and the parallel/behind test
	logic v_s2;
	logic [31:0] magnum_s2, magdz_s2;
	tdiv_side_t side_s2;
	logic [32:0] num_neg;
	logic [31:0] dz_neg;

	assign num_neg = -num_s1;
	assign dz_neg = -dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		magnum_s2 <= num_s1[32] ? num_neg[31:0] : num_s1[31:0];
		magdz_s2 <= dz_s1[31] ? dz_neg : dz_s1;
		side_s2.ox <= ox_s1;
		side_s2.oy <= oy_s1;
		side_s2.dx <= dx_s1;
		side_s2.dy <= dy_s1;
		side_s2.tmax <= tmax_s1;
		side_s2.miss <= (dz_s1 == '0) || (num_s1 == '0) || (num_s1[32] != dz_s1[31]);
	end

	// distance divider: t = |num| * 2^F / |dz|
	logic tdv_valid;
	logic [47:0] tdv_quo;
	tdiv_side_t tdv_side;

	rdi_divider #(.SW(32), .QW(48), .SBW($bits(tdiv_side_t))) u_tdiv (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s2),
		.rem_init(32'd0),
		.dvd({magnum_s2, 16'd0}),
		.dvs(magdz_s2),
		.side_in(side_s2),
		.out_valid(tdv_valid),
		.quo(tdv_quo),
		.side_out(tdv_side)
	);

	// stage 3: range test on t, direction magnitudes
	logic v_s3;
	logic [30:0] t_s3;
	logic miss_s3;
	logic [31:0] mdx_s3, mdy_s3;
	logic dxn_s3, dyn_s3;
	logic signed [31:0] ox_s3, oy_s3;
	logic [31:0] dx_neg, dy_neg;

	assign dx_neg = -tdv_side.dx;
	assign dy_neg = -tdv_side.dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= tdv_valid;
		end
	end

	always_ff @(posedge clk) begin
		t_s3 <= tdv_quo[30:0];
		miss_s3 <= tdv_side.miss || (tdv_quo == '0) || (tdv_quo[47:31] != '0)
			|| (tdv_quo[30:0] >= tdv_side.tmax);
		mdx_s3 <= tdv_side.dx[31] ? dx_neg : tdv_side.dx;
		mdy_s3 <= tdv_side.dy[31] ? dy_neg : tdv_side.dy;
		dxn_s3 <= tdv_side.dx[31];
		dyn_s3 <= tdv_side.dy[31];
		ox_s3 <= tdv_side.ox;
		oy_s3 <= tdv_side.oy;
	end

	// stage 4: |d| * t
	logic v_s4;
	logic [62:0] prodx_s4, prody_s4;
	logic [30:0] t_s4;
	logic miss_s4, dxn_s4, dyn_s4;
	logic signed [31:0] ox_s4, oy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		prodx_s4 <= 63'(mdx_s3) * 63'(t_s3);
		prody_s4 <= 63'(mdy_s3) * 63'(t_s3);
		t_s4 <= t_s3;
		miss_s4 <= miss_s3;
		dxn_s4 <= dxn_s3;
		dyn_s4 <= dyn_s3;
		ox_s4 <= ox_s3;
		oy_s4 <= oy_s3;
	end

	// stage 5: hit point coordinates
	logic v_s5;
	logic signed [48:0] px_s5, py_s5;
	logic [30:0] t_s5;
	logic miss_s5;
	logic signed [48:0] ox_ext, oy_ext, px_off, py_off;

	assign ox_ext = {{17{ox_s4[31]}}, ox_s4};
	assign oy_ext = {{17{oy_s4[31]}}, oy_s4};
	assign px_off = {2'b0, prodx_s4[62:FRAC]};
	assign py_off = {2'b0, prody_s4[62:FRAC]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		px_s5 <= dxn_s4 ? ox_ext - px_off : ox_ext + px_off;
		py_s5 <= dyn_s4 ? oy_ext - py_off : oy_ext + py_off;
		t_s5 <= t_s4;
		miss_s5 <= miss_s4;
	end

	// stage 6: coordinate magnitudes
	logic v_s6;
	logic [47:0] mpx_s6, mpy_s6;
	logic pxn_s6, pyn_s6;
	logic [30:0] t_s6;
	logic miss_s6;
	logic [48:0] px_neg, py_neg;

	assign px_neg = -px_s5;
	assign py_neg = -py_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		mpx_s6 <= px_s5[48] ? px_neg[47:0] : px_s5[47:0];
		mpy_s6 <= py_s5[48] ? py_neg[47:0] : py_s5[47:0];
		pxn_s6 <= px_s5[48];
		pyn_s6 <= py_s5[48];
		t_s6 <= t_s5;
		miss_s6 <= miss_s5;
	end

	// stage 7: far point reject
	logic v_s7;
	logic [30:0] ax_s7, ay_s7;
	logic pxn_s7, pyn_s7;
	logic [30:0] t_s7;
	logic miss_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		ax_s7 <= mpx_s6[30:0];
		ay_s7 <= mpy_s6[30:0];
		pxn_s7 <= pxn_s6;
		pyn_s7 <= pyn_s6;
		t_s7 <= t_s6;
		miss_s7 <= miss_s6 || (mpx_s6 > {17'd0, outer_q}) || (mpy_s6 > {17'd0, outer_q});
	end

	// stage 8: squares
	logic v_s8;
	logic [61:0] sqx_s8, sqy_s8;
	sqrt_side_t side_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s8 <= 62'(ax_s7) * 62'(ax_s7);
		sqy_s8 <= 62'(ay_s7) * 62'(ay_s7);
		side_s8.ax <= ax_s7;
		side_s8.ay <= ay_s7;
		side_s8.pxn <= pxn_s7;
		side_s8.pyn <= pyn_s7;
		side_s8.t <= t_s7;
		side_s8.miss <= miss_s7;
	end

	// stage 9: squared distance
	logic v_s9;
	logic [62:0] dist2_s9;
	sqrt_side_t side_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		dist2_s9 <= {1'b0, sqx_s8} + {1'b0, sqy_s8};
		side_s9 <= side_s8;
	end

	// stage 10: ring test
	logic v_s10;
	logic [62:0] dist2_s10;
	sqrt_side_t side_s10;
	sqrt_side_t ring_w;

	always_comb begin
		ring_w = side_s9;
		ring_w.miss = side_s9.miss || (dist2_s9 > {1'b0, rsq_q})
			|| (dist2_s9 < {1'b0, risq_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		dist2_s10 <= dist2_s9;
		side_s10 <= ring_w;
	end

	// radius
	logic sq_valid;
	logic [31:0] sq_root;
	sqrt_side_t sq_side;

	rdi_isqrt #(.SBW($bits(sqrt_side_t))) u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s10),
		.radicand({1'b0, dist2_s10}),
		.side_in(side_s10),
		.out_valid(sq_valid),
		.root(sq_root),
		.side_out(sq_side)
	);

	// first-quadrant angle
	cordic_side_t cd_side_in;
	cordic_side_t cd_side;
	logic cd_valid;
	logic [30:0] cd_angle;

	assign cd_side_in.r = sq_root;
	assign cd_side_in.pxn = sq_side.pxn;
	assign cd_side_in.pyn = sq_side.pyn;
	assign cd_side_in.t = sq_side.t;
	assign cd_side_in.miss = sq_side.miss;

	rdi_cordic #(.SBW($bits(cordic_side_t))) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(sq_valid),
		.ax(sq_side.ax),
		.ay(sq_side.ay),
		.side_in(cd_side_in),
		.out_valid(cd_valid),
		.angle(cd_angle),
		.side_out(cd_side)
	);

	// stage 11: quadrant mapping, radius clamp
	logic v_s11;
	logic [32:0] phi30_s11;
	logic [30:0] rcl_s11;
	logic [30:0] t_s11;
	logic miss_s11;
	logic [32:0] a_ext;

	assign a_ext = {2'b0, cd_angle};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else begin
			v_s11 <= cd_valid;
		end
	end

	always_ff @(posedge clk) begin
		case ({cd_side.pxn, cd_side.pyn})
			2'b00:   phi30_s11 <= a_ext;
			2'b10:   phi30_s11 <= ANG_PI - a_ext;
			2'b11:   phi30_s11 <= ANG_PI + a_ext;
			default: phi30_s11 <= ANG_TWO_PI - a_ext;
		endcase
		rcl_s11 <= (cd_side.r > {1'b0, outer_q}) ? outer_q : cd_side.r[30:0];
		t_s11 <= cd_side.t;
		miss_s11 <= cd_side.miss;
	end

	// stage 12: round angle to Q16, radial distance from the rim
	logic v_s12;
	logic [19:0] phi_s12;
	logic [30:0] dvr_s12;
	logic [30:0] t_s12;
	logic miss_s12;
	logic [32:0] phi_rnd;

	assign phi_rnd = (phi30_s11 + ANG_ROUND) >> (ANG_BITS - FRAC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		phi_s12 <= phi_rnd[19:0];
		dvr_s12 <= outer_q - rcl_s11;
		t_s12 <= t_s11;
		miss_s12 <= miss_s11;
	end

	// stage 13: sweep test
	logic v_s13;
	logic [19:0] phi_s13;
	logic [30:0] dvr_s13;
	udiv_side_t side_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else begin
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		phi_s13 <= phi_s12;
		dvr_s13 <= dvr_s12;
		side_s13.t <= t_s12;
		side_s13.miss <= miss_s12 || (phi_s12 > {1'b0, sweep_q});
	end

	// u = phi * 2^F / sweep, v = (R - r) * 2^F / (R - Ri); both quotients fit 17 bits
	logic ud_valid;
	logic [16:0] ud_quo;
	udiv_side_t ud_side;
	logic vd_valid;
	logic [16:0] vd_quo;
	logic vd_side;

	rdi_divider #(.SW(19), .QW(17), .SBW($bits(udiv_side_t))) u_udiv (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s13),
		.rem_init(phi_s13[19:1]),
		.dvd({phi_s13[0], 16'd0}),
		.dvs(sweep_q),
		.side_in(side_s13),
		.out_valid(ud_valid),
		.quo(ud_quo),
		.side_out(ud_side)
	);

	rdi_divider #(.SW(31), .QW(17), .SBW(1)) u_vdiv (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v_s13),
		.rem_init({1'b0, dvr_s13[30:1]}),
		.dvd({dvr_s13[0], 16'd0}),
		.dvs(width_w),
		.side_in(side_s13.miss),
		.out_valid(vd_valid),
		.quo(vd_quo),
		.side_out(vd_side)
	);

	// stage 14: result register, zeros on a miss
	logic v_s14;
	logic hit_s14;
	logic [30:0] t_s14;
	logic [16:0] u_s14, vv_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s14 <= 1'b0;
		end else begin
			v_s14 <= ud_valid && vd_valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_s14 <= !ud_side.miss;
		t_s14 <= ud_side.miss ? 31'd0 : ud_side.t;
		u_s14 <= (ud_side.miss || sweep_q == '0) ? 17'd0 : ud_quo;
		vv_s14 <= (vd_side || width_w == '0) ? 17'd0 : vd_quo;
	end

	assign done = v_s14;
	assign hit = hit_s14;
	assign t_hit = t_s14;
	assign u_coord = u_s14;
	assign v_coord = vv_s14;

endmodule

`default_nettype wire

@@ hw/rtl/rdi_divider.sv @@
// rdi_divider: pipelined restoring divider, one quotient bit per stage
// standalone, no package use
`default_nettype none

module rdi_divider #(
	parameter int SW = 32,
	parameter int QW = 48,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [SW-1:0]  rem_init,
	input  logic [QW-1:0]  dvd,
	input  logic [SW-1:0]  dvs,
	input  logic [SBW-1:0] side_in,
	output logic           out_valid,
	output logic [QW-1:0]  quo,
	output logic [SBW-1:0] side_out
);

	logic           valid_s [0:QW];
	logic [SW-1:0]  rem_s [0:QW];
	logic [QW-1:0]  dvd_s [0:QW];
	logic [QW-1:0]  quo_s [0:QW];
	logic [SW-1:0]  dvs_s [0:QW];
	logic [SBW-1:0] side_s [0:QW];

	// stage zero is the request itself
	assign valid_s[0] = in_valid;
	assign rem_s[0] = rem_init;
	assign dvd_s[0] = dvd;
	assign quo_s[0] = '0;
	assign dvs_s[0] = dvs;
	assign side_s[0] = side_in;

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_step
			logic [SW:0] trial;
			logic [SW:0] diff;
			logic ge;

			// shift in the next dividend bit and try the subtract
			assign trial = {rem_s[k], dvd_s[k][QW-1]};
			assign diff = trial - {1'b0, dvs_s[k]};
			assign ge = trial >= {1'b0, dvs_s[k]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k+1] <= 1'b0;
				end else begin
					valid_s[k+1] <= valid_s[k];
				end
			end

			always_ff @(posedge clk) begin
				rem_s[k+1] <= ge ? diff[SW-1:0] : trial[SW-1:0];
				dvd_s[k+1] <= {dvd_s[k][QW-2:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][QW-2:0], ge};
				dvs_s[k+1] <= dvs_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	endgenerate

	assign out_valid = valid_s[QW];
	assign quo = quo_s[QW];
	assign side_out = side_s[QW];

endmodule

`default_nettype wire

@@ hw/rtl/rdi_isqrt.sv @@
// rdi_isqrt: pipelined integer square root of a 64-bit value, one result bit per stage
// standalone, no package use
`default_nettype none

module rdi_isqrt #(
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [63:0]    radicand,
	input  logic [SBW-1:0] side_in,
	output logic           out_valid,
	output logic [31:0]    root,
	output logic [SBW-1:0] side_out
);

	logic           valid_s [0:32];
	logic [63:0]    rem_s [0:32];
	logic [63:0]    res_s [0:32];
	logic [SBW-1:0] side_s [0:32];

	assign valid_s[0] = in_valid;
	assign rem_s[0] = radicand;
	assign res_s[0] = '0;
	assign side_s[0] = side_in;

	genvar k;
	generate
		for (k = 0; k < 32; k++) begin : g_step
			localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
			logic [63:0] trial;
			logic ge;

			// test one result bit against the remainder
			assign trial = res_s[k] + BIT;
			assign ge = rem_s[k] >= trial;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[k+1] <= 1'b0;
				end else begin
					valid_s[k+1] <= valid_s[k];
				end
			end

			always_ff @(posedge clk) begin
				rem_s[k+1] <= ge ? rem_s[k] - trial : rem_s[k];
				res_s[k+1] <= ge ? (res_s[k] >> 1) + BIT : res_s[k] >> 1;
				side_s[k+1] <= side_s[k];
			end
		end
	endgenerate

	assign out_valid = valid_s[32];
	assign root = res_s[32][31:0];
	assign side_out = side_s[32];

endmodule

`default_nettype wire

@@ hw/rtl/rdi_cordic.sv @@
// rdi_cordic: first-quadrant angle of (ax, ay) in Q30, normalize then cordic vectoring
// depends on rdi_pkg (angle table and constants)
`default_nettype none

module rdi_cordic #(
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [30:0]    ax,
	input  logic [30:0]    ay,
	input  logic [SBW-1:0] side_in,
	output logic           out_valid,
	output logic [30:0]    angle,
	output logic [SBW-1:0] side_out
);

	import rdi_pkg::*;

	localparam int NS = 5;
	localparam int NR = CORDIC_STEPS;

	// normalizing shifter stages
	logic           nvalid_s [0:NS];
	logic [30:0]    nx_s [0:NS];
	logic [30:0]    ny_s [0:NS];
	logic [30:0]    nm_s [0:NS];
	logic           nzx_s [0:NS];
	logic           nzy_s [0:NS];
	logic [SBW-1:0] nside_s [0:NS];

	// rotation stages
	logic               rvalid_s [0:NR];
	logic signed [34:0] x_s [0:NR];
	logic signed [34:0] y_s [0:NR];
	logic signed [32:0] z_s [0:NR];
	logic               rzx_s [0:NR];
	logic               rzy_s [0:NR];
	logic [SBW-1:0]     rside_s [0:NR];

	logic        valid_q;
	logic [30:0] angle_q;
	logic [SBW-1:0] side_q;

	assign nvalid_s[0] = in_valid;
	assign nx_s[0] = ax;
	assign ny_s[0] = ay;
	assign nm_s[0] = (ax > ay) ? ax : ay;
	assign nzx_s[0] = ax == '0;
	assign nzy_s[0] = ay == '0;
	assign nside_s[0] = side_in;

	genvar j, k;
	generate
		// binary search on the leading one: shift by 16, 8, 4, 2, 1
		for (j = 0; j < NS; j++) begin : g_norm
			localparam int SH = 16 >> j;
			logic lead_zero;

			assign lead_zero = nm_s[j][30:31-SH] == '0;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					nvalid_s[j+1] <= 1'b0;
				end else begin
					nvalid_s[j+1] <= nvalid_s[j];
				end
			end

			always_ff @(posedge clk) begin
				nx_s[j+1] <= lead_zero ? nx_s[j] << SH : nx_s[j];
				ny_s[j+1] <= lead_zero ? ny_s[j] << SH : ny_s[j];
				nm_s[j+1] <= lead_zero ? nm_s[j] << SH : nm_s[j];
				nzx_s[j+1] <= nzx_s[j];
				nzy_s[j+1] <= nzy_s[j];
				nside_s[j+1] <= nside_s[j];
			end
		end
	endgenerate

	assign rvalid_s[0] = nvalid_s[NS];
	assign x_s[0] = $signed({4'b0, nx_s[NS]});
	assign y_s[0] = $signed({4'b0, ny_s[NS]});
	assign z_s[0] = '0;
	assign rzx_s[0] = nzx_s[NS];
	assign rzy_s[0] = nzy_s[NS];
	assign rside_s[0] = nside_s[NS];

	generate
		// one micro-rotation per stage, steering y toward zero
		for (k = 0; k < NR; k++) begin : g_rot
			localparam logic signed [32:0] ATAN = $signed({2'b0, atan_q30(k)});
			logic signed [34:0] ysh;
			logic signed [34:0] xsh;
			logic up;

			assign ysh = y_s[k] >>> k;
			assign xsh = x_s[k] >>> k;
			assign up = !y_s[k][34];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					rvalid_s[k+1] <= 1'b0;
				end else begin
					rvalid_s[k+1] <= rvalid_s[k];
				end
			end

			always_ff @(posedge clk) begin
				x_s[k+1] <= up ? x_s[k] + ysh : x_s[k] - ysh;
				y_s[k+1] <= up ? y_s[k] - xsh : y_s[k] + xsh;
				z_s[k+1] <= up ? z_s[k] + ATAN : z_s[k] - ATAN;
				rzx_s[k+1] <= rzx_s[k];
				rzy_s[k+1] <= rzy_s[k];
				rside_s[k+1] <= rside_s[k];
			end
		end
	endgenerate

	// axis cases, then clamp to [0, pi/2]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= rvalid_s[NR];
		end
	end

	always_ff @(posedge clk) begin
		if (rzy_s[NR]) begin
			angle_q <= '0;
		end else if (rzx_s[NR]) begin
			angle_q <= ANG_HALF_PI;
		end else if (z_s[NR][32]) begin
			angle_q <= '0;
		end else if (z_s[NR] > $signed({2'b0, ANG_HALF_PI})) begin
			angle_q <= ANG_HALF_PI;
		end else begin
			angle_q <= z_s[NR][30:0];
		end
		side_q <= rside_s[NR];
	end

	assign out_valid = valid_q;
	assign angle = angle_q;
	assign side_out = side_q;

endmodule

`default_nettype wire
